/* rtl/core/crr_pkg.sv */
`default_nettype none

package crr_pkg;

    localparam int LEVEL_BITS_DEF  = 24;
    localparam int LENGTH_BITS_DEF = 20;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_ENABLE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CURVE  = 2'd1;

    localparam int DIV_W     = 64;
    localparam int DVS_W     = 34;
    localparam int DIV_CNT_W = 7;
    localparam int MUL_W     = 33;

    localparam logic [31:0] ONE_Q30   = 32'h4000_0000;
    localparam logic [31:0] LN2_Q30   = 32'd744261118;
    localparam logic [16:0] SHAPE_ONE = 17'h1_0000;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SHAPE,
        ST_DIV_WAIT,
        ST_MUL_CP,
        ST_CP_GET,
        ST_LOG_INIT,
        ST_LOG_MUL,
        ST_LOG_STEP,
        ST_ISSUE_POS,
        ST_MUL_T,
        ST_T_GET,
        ST_MUL_X,
        ST_X_GET,
        ST_MUL_TERM,
        ST_TERM_DIV,
        ST_EXP_END,
        ST_APPLY,
        ST_APPLY_GET
    } st_t;

    typedef enum logic [2:0] {
        OP_LIN,
        OP_P32,
        OP_POS,
        OP_TERM,
        OP_NEG
    } div_op_t;

    typedef enum logic [1:0] {
        RET_NUM,
        RET_DEN,
        RET_LC
    } log_ret_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     dividend;
        logic [DVS_W-1:0]     divisor;
        logic [DIV_CNT_W-1:0] iters;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

/* rtl/core/curved_release_ramp_unit.sv */
`default_nettype none
// When the ramp is cleared or ends, the result goes straight to the multiply and the
// output register; a linear or curved shape first runs the bit-serial divider and,
// for a curve, the shared multiplier through the log and, if negative, power steps.
// A new item is taken only after the last result is in the output register; it is
// taken while that result waits, and a finished result holds until the register is free.
// Reset: synchronous active-low aresetn clears control, ramp state and registers.
module curved_release_ramp_unit #(
    parameter int LEVEL_BITS  = crr_pkg::LEVEL_BITS_DEF,
    parameter int LENGTH_BITS = crr_pkg::LENGTH_BITS_DEF
) (
    input  wire logic                                         aclk,
    input  wire logic                                         aresetn,
    input  wire logic                                         cfg_we,
    input  wire logic [crr_pkg::CFG_INDEX_W-1:0]              cfg_index,
    input  wire logic [crr_pkg::CFG_DATA_W-1:0]               cfg_wdata,
    input  wire logic                                         s_tvalid,
    output logic                                              s_tready,
    // current_level, goal_level, release_length
    input  wire logic [((2*LEVEL_BITS+LENGTH_BITS+7)/8)*8-1:0] s_tdata,
    output logic                                              m_tvalid,
    input  wire logic                                         m_tready,
    // released_level
    output logic      [((LEVEL_BITS+7)/8)*8-1:0]              m_tdata,
    // still_releasing
    output logic      [0:0]                                   m_tuser
);
    import crr_pkg::*;

    localparam int OUT_W  = ((LEVEL_BITS+7)/8)*8;
    localparam int LIN_IT = LENGTH_BITS + 17;
    localparam int P32_IT = LENGTH_BITS + 32;
    localparam int POS_IT = 50;
    localparam int TRM_IT = 31;
    localparam int NEG_IT = 42;
    localparam int LB     = LEVEL_BITS;
    localparam int NB     = LENGTH_BITS;

    st_t      state_reg, state_next;
    div_op_t  div_op_reg, div_op_next;
    log_ret_t log_ret_reg, log_ret_next;

    logic          enable_reg;
    logic [15:0]   curve_reg;
    logic [LB-1:0] ramp_start_reg, ramp_start_next;
    logic [LB-1:0] ramp_goal_reg, ramp_goal_next;
    logic [NB-1:0] ramp_elapsed_reg, ramp_elapsed_next;
    logic [NB-1:0] ramp_length_reg, ramp_length_next;
    logic          ramp_active_reg, ramp_active_next;
    logic [21:0]   m99_reg, m99_next;
    logic [31:0]   p32_reg, p32_next;
    logic [39:0]   log_x_reg, log_x_next;
    logic [31:0]   log_y_reg, log_y_next;
    logic [32:0]   log_r_reg, log_r_next;
    logic [4:0]    log_i_reg, log_i_next;
    logic [32:0]   num_reg, num_next;
    logic [32:0]   lc_reg, lc_next;
    logic [32:0]   t_reg, t_next;
    logic [29:0]   x_reg, x_next;
    logic [30:0]   term_reg, term_next;
    logic [31:0]   sum_reg, sum_next;
    logic [4:0]    i_reg, i_next;
    logic [16:0]   s_reg, s_next;
    logic          res_flag_reg, res_flag_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [LB-1:0] m_level_reg, m_level_next;
    logic          m_flag_reg, m_flag_next;

    logic [MUL_W-1:0]   mul_a, mul_b;
    logic [2*MUL_W-1:0] mul_p;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    logic [LB-1:0]      cur_in, goal_in;
    logic [NB-1:0]      len_in, len_l, e_old, e_new;
    logic [15:0]        mag;
    logic               curved;
    logic [3:0]         log_n;
    logic [31:0]        yy;
    logic [32:0]        r_new;
    logic [39:0]        cx;
    logic [38:0]        pw, ex;
    logic [2*MUL_W-1:0] rnd;
    logic [LB-1:0]      drop, lvl;

    crr_mul u_mul (
        .aclk  (aclk),
        .a     (mul_a),
        .b     (mul_b),
        .p_reg (mul_p)
    );

    crr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign cur_in  = s_tdata[LB-1:0];
    assign goal_in = s_tdata[2*LB-1:LB];
    assign len_in  = s_tdata[2*LB+NB-1:2*LB];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'(m_level_reg);
    assign m_tuser  = m_flag_reg;

    assign mag    = curve_reg[15] ? 16'(~curve_reg + 16'd1) : curve_reg;
    assign curved = enable_reg && (curve_reg != 16'd0);
    assign cx     = (40'd1 << 32) + (40'(m99_reg) << 17);
    assign len_l  = ramp_active_reg ? ramp_length_reg : len_in;
    assign e_old  = ramp_active_reg ? ramp_elapsed_reg : '0;
    assign e_new  = (e_old < len_l) ? NB'(e_old + NB'(1)) : e_old;

    always_comb begin
        log_n = 4'd0;
        for (int k = 0; k < 7; k++) begin
            log_n = log_n + {3'd0, ((log_x_reg >> (33 + k)) != 40'd0)};
        end
    end

    assign yy    = mul_p[61:30];
    assign r_new = yy[31] ? (log_r_reg | (33'd1 << log_i_reg)) : log_r_reg;
    assign pw    = 39'(sum_reg) << t_reg[32:30];
    assign ex    = (pw > 39'(ONE_Q30)) ? 39'(pw - 39'(ONE_Q30)) : '0;
    assign rnd   = mul_p + (2*MUL_W)'(32768);
    assign drop  = rnd[LB+15:16];

    always_comb begin
        lvl = (ramp_start_reg > ramp_goal_reg) ? LB'(ramp_start_reg - drop) : ramp_start_reg;
        if (lvl < ramp_goal_reg) begin
            lvl = ramp_goal_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            curve_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ENABLE: enable_reg <= cfg_wdata[0];
                REG_CURVE:  curve_reg  <= cfg_wdata[15:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        state_next        = state_reg;
        div_op_next       = div_op_reg;
        log_ret_next      = log_ret_reg;
        ramp_start_next   = ramp_start_reg;
        ramp_goal_next    = ramp_goal_reg;
        ramp_elapsed_next = ramp_elapsed_reg;
        ramp_length_next  = ramp_length_reg;
        ramp_active_next  = ramp_active_reg;
        m99_next          = m99_reg;
        p32_next          = p32_reg;
        log_x_next        = log_x_reg;
        log_y_next        = log_y_reg;
        log_r_next        = log_r_reg;
        log_i_next        = log_i_reg;
        num_next          = num_reg;
        lc_next           = lc_reg;
        t_next            = t_reg;
        x_next            = x_reg;
        term_next         = term_reg;
        sum_next          = sum_reg;
        i_next            = i_reg;
        s_next            = s_reg;
        res_flag_next     = res_flag_reg;
        m_level_next      = m_level_reg;
        m_flag_next       = m_flag_reg;
        m_tvalid_next     = m_tvalid_reg && !m_tready;
        mul_a             = '0;
        mul_b             = '0;
        div_req           = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (len_in == '0 || goal_in >= cur_in) begin
                        ramp_active_next = 1'b0;
                        s_next           = '0;
                        ramp_start_next  = goal_in;
                        ramp_goal_next   = goal_in;
                        res_flag_next    = 1'b0;
                        state_next       = ST_APPLY;
                    end else begin
                        if (!ramp_active_reg) begin
                            ramp_start_next  = cur_in;
                            ramp_goal_next   = goal_in;
                            ramp_length_next = len_in;
                        end
                        ramp_elapsed_next = e_new;
                        m99_next          = 22'(mag) * 22'd99;
                        if (e_new >= len_l) begin
                            ramp_active_next = 1'b0;
                            res_flag_next    = 1'b0;
                            s_next           = SHAPE_ONE;
                            state_next       = ST_APPLY;
                        end else begin
                            ramp_active_next = 1'b1;
                            res_flag_next    = 1'b1;
                            state_next       = ST_SHAPE;
                        end
                    end
                end
            end
            ST_SHAPE: begin
                div_req.start   = 1'b1;
                div_req.divisor = DVS_W'(ramp_length_reg);
                if (curved) begin
                    div_req.dividend = (DIV_W'(ramp_elapsed_reg) << 32) << (DIV_W - P32_IT);
                    div_req.iters    = DIV_CNT_W'(P32_IT);
                    div_op_next      = OP_P32;
                end else begin
                    div_req.dividend = ((DIV_W'(ramp_elapsed_reg) << 16)
                                       + DIV_W'(ramp_length_reg >> 1)) << (DIV_W - LIN_IT);
                    div_req.iters    = DIV_CNT_W'(LIN_IT);
                    div_op_next      = OP_LIN;
                end
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    case (div_op_reg)
                        OP_P32: begin
                            p32_next = div_rsp.quotient[31:0];
                            if (curve_reg[15]) begin
                                log_x_next   = cx;
                                log_ret_next = RET_LC;
                                state_next   = ST_LOG_INIT;
                            end else begin
                                state_next = ST_MUL_CP;
                            end
                        end
                        OP_TERM: begin
                            term_next = div_rsp.quotient[30:0];
                            sum_next  = sum_reg + 32'(div_rsp.quotient[30:0]);
                            if (i_reg == 5'd16) begin
                                state_next = ST_EXP_END;
                            end else begin
                                i_next     = i_reg + 5'd1;
                                state_next = ST_MUL_TERM;
                            end
                        end
                        default: begin
                            s_next = (div_rsp.quotient > DIV_W'(SHAPE_ONE))
                                   ? SHAPE_ONE : div_rsp.quotient[16:0];
                            state_next = ST_APPLY;
                        end
                    endcase
                end
            end
            ST_MUL_CP: begin
                mul_a      = MUL_W'(p32_reg);
                mul_b      = MUL_W'(m99_reg);
                state_next = ST_CP_GET;
            end
            ST_CP_GET: begin
                log_x_next   = (40'd1 << 32) + 40'(mul_p[53:15]);
                log_ret_next = RET_NUM;
                state_next   = ST_LOG_INIT;
            end
            ST_LOG_INIT: begin
                log_y_next = 32'(log_x_reg >> (log_n + 4'd2));
                log_r_next = 33'(log_n) << 30;
                log_i_next = 5'd29;
                state_next = ST_LOG_MUL;
            end
            ST_LOG_MUL: begin
                mul_a      = MUL_W'(log_y_reg);
                mul_b      = MUL_W'(log_y_reg);
                state_next = ST_LOG_STEP;
            end
            ST_LOG_STEP: begin
                log_y_next = yy[31] ? {1'b0, yy[31:1]} : yy;
                log_r_next = r_new;
                if (log_i_reg == 5'd0) begin
                    unique case (log_ret_reg)
                        RET_NUM: begin
                            num_next     = r_new;
                            log_x_next   = cx;
                            log_ret_next = RET_DEN;
                            state_next   = ST_LOG_INIT;
                        end
                        RET_DEN: begin
                            lc_next    = r_new;
                            state_next = ST_ISSUE_POS;
                        end
                        default: begin
                            lc_next    = r_new;
                            state_next = ST_MUL_T;
                        end
                    endcase
                end else begin
                    log_i_next = log_i_reg - 5'd1;
                    state_next = ST_LOG_MUL;
                end
            end
            ST_ISSUE_POS: begin
                div_req.start    = 1'b1;
                div_req.divisor  = DVS_W'(lc_reg);
                div_req.dividend = ((DIV_W'(num_reg) << 16) + DIV_W'(lc_reg >> 1))
                                   << (DIV_W - POS_IT);
                div_req.iters    = DIV_CNT_W'(POS_IT);
                div_op_next      = OP_POS;
                state_next       = ST_DIV_WAIT;
            end
            ST_MUL_T: begin
                mul_a      = MUL_W'(p32_reg[31:2]);
                mul_b      = lc_reg;
                state_next = ST_T_GET;
            end
            ST_T_GET: begin
                t_next     = mul_p[62:30];
                state_next = ST_MUL_X;
            end
            ST_MUL_X: begin
                mul_a      = MUL_W'(t_reg[29:0]);
                mul_b      = MUL_W'(LN2_Q30);
                state_next = ST_X_GET;
            end
            ST_X_GET: begin
                x_next     = mul_p[59:30];
                term_next  = 31'(ONE_Q30);
                sum_next   = ONE_Q30;
                i_next     = 5'd1;
                state_next = ST_MUL_TERM;
            end
            ST_MUL_TERM: begin
                mul_a      = MUL_W'(term_reg);
                mul_b      = MUL_W'(x_reg);
                state_next = ST_TERM_DIV;
            end
            ST_TERM_DIV: begin
                div_req.start    = 1'b1;
                div_req.divisor  = DVS_W'(i_reg);
                div_req.dividend = DIV_W'(mul_p[60:30]) << (DIV_W - TRM_IT);
                div_req.iters    = DIV_CNT_W'(TRM_IT);
                div_op_next      = OP_TERM;
                state_next       = ST_DIV_WAIT;
            end
            ST_EXP_END: begin
                div_req.start    = 1'b1;
                div_req.divisor  = DVS_W'(m99_reg) << 1;
                div_req.dividend = ((DIV_W'(ex) << 2) + DIV_W'(m99_reg)) << (DIV_W - NEG_IT);
                div_req.iters    = DIV_CNT_W'(NEG_IT);
                div_op_next      = OP_NEG;
                state_next       = ST_DIV_WAIT;
            end
            ST_APPLY: begin
                mul_a      = MUL_W'(ramp_start_reg - ramp_goal_reg);
                mul_b      = MUL_W'(s_reg);
                state_next = ST_APPLY_GET;
            end
            ST_APPLY_GET: begin
                // hold the product until the output register is free
                mul_a = MUL_W'(ramp_start_reg - ramp_goal_reg);
                mul_b = MUL_W'(s_reg);
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_level_next  = lvl;
                    m_flag_next   = res_flag_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            ramp_active_reg  <= 1'b0;
            ramp_start_reg   <= '0;
            ramp_goal_reg    <= '0;
            ramp_elapsed_reg <= '0;
            ramp_length_reg  <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg        <= state_next;
            ramp_active_reg  <= ramp_active_next;
            ramp_start_reg   <= ramp_start_next;
            ramp_goal_reg    <= ramp_goal_next;
            ramp_elapsed_reg <= ramp_elapsed_next;
            ramp_length_reg  <= ramp_length_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
        div_op_reg   <= div_op_next;
        log_ret_reg  <= log_ret_next;
        m99_reg      <= m99_next;
        p32_reg      <= p32_next;
        log_x_reg    <= log_x_next;
        log_y_reg    <= log_y_next;
        log_r_reg    <= log_r_next;
        log_i_reg    <= log_i_next;
        num_reg      <= num_next;
        lc_reg       <= lc_next;
        t_reg        <= t_next;
        x_reg        <= x_next;
        term_reg     <= term_next;
        sum_reg      <= sum_next;
        i_reg        <= i_next;
        s_reg        <= s_next;
        res_flag_reg <= res_flag_next;
        m_level_reg  <= m_level_next;
        m_flag_reg   <= m_flag_next;
    end

endmodule

`default_nettype wire

/* rtl/core/crr_mul.sv */
`default_nettype none

module crr_mul (
    input  wire logic                          aclk,
    input  wire logic [crr_pkg::MUL_W-1:0]     a,
    input  wire logic [crr_pkg::MUL_W-1:0]     b,
    output logic      [2*crr_pkg::MUL_W-1:0]   p_reg
);
    import crr_pkg::*;

    logic [2*MUL_W-1:0] p_next;

    assign p_next = (2*MUL_W)'(a) * (2*MUL_W)'(b);

    always_ff @(posedge aclk) begin
        p_reg <= p_next;
    end

endmodule

`default_nettype wire

/* rtl/core/crr_div.sv */
`default_nettype none

module crr_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire crr_pkg::div_req_t req,
    output crr_pkg::div_rsp_t      rsp
);
    import crr_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0]     rem_reg, rem_next;
    logic [DVS_W-1:0]     dvs_reg, dvs_next;
    logic [DIV_W-1:0]     q_reg, q_next;
    logic [DVS_W:0]       rem_sh;
    logic                 ge;

    assign rem_sh = {rem_reg, q_reg[DIV_W-1]};
    assign ge     = rem_sh >= {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        q_next    = q_reg;
        done_next = busy_reg && (cnt_reg == DIV_CNT_W'(1));
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = req.iters;
            rem_next  = '0;
            dvs_next  = req.divisor;
            q_next    = req.dividend;
        end else if (busy_reg) begin
            rem_next = ge ? DVS_W'(rem_sh - {1'b0, dvs_reg}) : DVS_W'(rem_sh);
            q_next   = {q_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        q_reg   <= q_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule

`default_nettype wire

/* dv/tb_curved_release_ramp_unit.sv */
`timescale 1ns / 100ps

module tb_curved_release_ramp_unit;
    import crr_pkg::*;

    localparam int LVL_W      = LEVEL_BITS_DEF;
    localparam int LEN_W      = LENGTH_BITS_DEF;
    localparam int SD_W       = ((2*LVL_W+LEN_W+7)/8)*8;
    localparam int MD_W       = ((LVL_W+7)/8)*8;
    localparam int CYCLE_CAP  = 20000000;
    localparam int HOLD_LEN   = 3000;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_3 = 2'd3;
    localparam longint unsigned LN2_C = 64'd744261118;
    localparam longint unsigned Q30_1 = 64'd1 << 30;
    localparam longint unsigned Q32_1 = 64'd1 << 32;

    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic             active;
    } release_out_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [SD_W-1:0]        s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [MD_W-1:0]        m_tdata;
    logic [0:0]             m_tuser;

    curved_release_ramp_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // predictor copy of registers and ramp state
    logic                  shape_en;
    logic signed [15:0]    curve;
    logic [LVL_W-1:0]      rs_start, rs_goal;
    logic [LEN_W-1:0]      rs_elapsed, rs_length;
    logic                  rs_active;

    release_out_t          pending_levels[$];
    int                    err_cnt = 0;
    int                    cycle_cnt = 0;
    bit                    idle_on = 1'b1;
    int                    hold_req = 0;
    int                    hold_seen = 0;
    int                    hold_left = 0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_CAP) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic longint unsigned log2_fix(longint unsigned x);
        int unsigned     n;
        longint unsigned y, r;
        n = 0;
        while (n < 7 && (x >> (n + 33)) != 0) n++;
        y = x >> (n + 2);
        r = longint'(n) << 30;
        for (int i = 29; i >= 0; i--) begin
            y = (y * y) >> 30;
            if (y >= (Q30_1 << 1)) begin
                y = y >> 1;
                r = r | (64'd1 << i);
            end
        end
        return r;
    endfunction

    function automatic longint unsigned pow2_fix(longint unsigned t);
        longint unsigned k, x, term, sum;
        k = t >> 30;
        x = ((t & (Q30_1 - 1)) * LN2_C) >> 30;
        term = Q30_1;
        sum = Q30_1;
        for (int i = 1; i <= 16; i++) begin
            term = ((term * x) >> 30) / i;
            sum += term;
        end
        if (k > 7) k = 7;
        return sum << k;
    endfunction

    function automatic longint unsigned ramp_shape(longint unsigned e, longint unsigned len);
        longint unsigned s, mag, p32, num, den, lc, t, pw, ex;
        int              cv;
        cv = curve;
        if (!shape_en || cv == 0) return ((e << 16) + (len >> 1)) / len;
        mag = (cv < 0) ? -cv : cv;
        p32 = (e << 32) / len;
        if (cv > 0) begin
            num = log2_fix(Q32_1 + ((p32 * 99 * mag) >> 15));
            den = log2_fix(Q32_1 + ((99 * mag) << 17));
            if (den == 0) return 65536;
            s = ((num << 16) + (den >> 1)) / den;
        end else begin
            lc = log2_fix(Q32_1 + ((99 * mag) << 17));
            t = ((p32 >> 2) * lc) >> 30;
            pw = pow2_fix(t);
            ex = (pw > Q30_1) ? pw - Q30_1 : 0;
            s = (4 * ex + 99 * mag) / (198 * mag);
        end
        return (s > 65536) ? 65536 : s;
    endfunction

    function automatic release_out_t release_step(logic [LVL_W-1:0] cur,
                                                  logic [LVL_W-1:0] goal,
                                                  logic [LEN_W-1:0] len);
        release_out_t    r;
        longint unsigned s, lvl, drop;
        if (len == 0 || goal >= cur) begin
            rs_active = 1'b0;
            r.level = goal;
            r.active = 1'b0;
            return r;
        end
        if (!rs_active) begin
            rs_start = cur;
            rs_goal = goal;
            rs_elapsed = '0;
            rs_length = len;
            rs_active = 1'b1;
        end
        if (rs_elapsed < rs_length) rs_elapsed = rs_elapsed + 1'b1;
        if (rs_elapsed >= rs_length) begin
            s = 65536;
            rs_active = 1'b0;
        end else begin
            s = ramp_shape(rs_elapsed, rs_length);
        end
        if (rs_start > rs_goal) begin
            drop = ((longint'(rs_start) - rs_goal) * s + 32768) >> 16;
            lvl = rs_start - drop;
        end else begin
            lvl = rs_start;
        end
        if (lvl < rs_goal) lvl = rs_goal;
        r.level = lvl[LVL_W-1:0];
        r.active = rs_active;
        return r;
    endfunction

    always @(posedge aclk) begin
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_LEN;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !(idle_on && $urandom_range(99) < 6);
        end
    end

    always @(posedge aclk) begin
        release_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_levels.size() == 0) begin
                $error("unexpected transfer: released_level %0h", m_tdata[LVL_W-1:0]);
                err_cnt++;
            end else begin
                want = pending_levels.pop_front();
                if (m_tdata[LVL_W-1:0] !== want.level) begin
                    $error("released_level expected %0h actual %0h",
                           want.level, m_tdata[LVL_W-1:0]);
                    err_cnt++;
                end
                if (m_tuser[0] !== want.active) begin
                    $error("still_releasing expected %0b actual %0b", want.active, m_tuser[0]);
                    err_cnt++;
                end
            end
        end
    end

    task automatic send_item(logic [LVL_W-1:0] cur, logic [LVL_W-1:0] goal,
                             logic [LEN_W-1:0] len);
        while (idle_on && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= SD_W'({len, goal, cur});
        do @(posedge aclk); while (!s_tready);
        pending_levels.push_back(release_step(cur, goal, len));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_levels.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_ENABLE) shape_en = val[0];
        else if (idx == REG_CURVE) curve = val;
    endtask

    task automatic set_shape(logic en, logic [15:0] cv);
        drain();
        write_reg(REG_ENABLE, {15'h7FFF, en});
        write_reg(REG_CURVE, cv);
    endtask

    task automatic test_directed();
        send_item(24'hFFFFFF, 24'h000000, 20'd0);
        send_item(24'h100000, 24'h100000, 20'd5);
        send_item(24'h000000, 24'hFFFFFF, 20'hFFFFF);
        send_item(24'hFFFFFF, 24'h000000, 20'd1);
        for (int i = 0; i < 4; i++) send_item(24'hFFFFFF, 24'h000000, 20'd3);
        for (int i = 0; i < 3; i++) send_item(24'hC00000, 24'h000001, 20'hFFFFF);
        send_item(24'h800000, 24'h7FFFFF, 20'd2);
        send_item(24'h800000, 24'h200000, 20'd4);
        send_item(24'h900000, 24'h000000, 20'd1);
        send_item(24'h900000, 24'h700000, 20'd9);
        send_item(24'h000001, 24'h000000, 20'd2);
        send_item(24'h000001, 24'h000000, 20'd2);
        send_item(24'hFFFFFF, 24'hFFFFFE, 20'd0);
    endtask

    task automatic test_ramps(int n_items);
        int               sent, steps;
        logic [LVL_W-1:0] c0, g0, cur;
        logic [LEN_W-1:0] len;
        sent = 0;
        while (sent < n_items) begin
            c0 = $urandom_range(24'hFFFFFF, 1);
            g0 = $urandom_range(c0 - 1, 0);
            case ($urandom_range(9))
                0:       len = $urandom;
                1, 2:    len = $urandom_range(300, 25);
                default: len = $urandom_range(24, 1);
            endcase
            steps = (len <= 24) ? len + $urandom_range(2) : $urandom_range(30, 1);
            send_item(c0, g0, len);
            sent++;
            for (int i = 1; i < steps && sent < n_items; i++) begin
                if ($urandom_range(99) < 5) begin
                    send_item($urandom, $urandom, $urandom);
                end else begin
                    g0 = ($urandom_range(1)) ? g0 : $urandom_range(c0 - 1, 0);
                    cur = $urandom_range(24'hFFFFFF, g0 + 1);
                    send_item(cur, g0, $urandom_range(1) ? len : LEN_W'($urandom_range(20'hFFFFF, 1)));
                end
                sent++;
            end
        end
    endtask

    task automatic test_backpressure();
        set_shape(1'b0, 16'h0000);
        hold_req = hold_req + 1;
        test_ramps(40);
        drain();
    endtask

    initial begin
        shape_en = 1'b0;
        curve = '0;
        rs_start = '0;
        rs_goal = '0;
        rs_elapsed = '0;
        rs_length = '0;
        rs_active = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        set_shape(1'b1, 16'h7FFF);
        test_directed();
        set_shape(1'b1, 16'h8000);
        test_directed();
        drain();
        write_reg(REG_UNUSED_2, 16'hFFFF);
        write_reg(REG_UNUSED_3, 16'h0000);

        set_shape(1'b0, 16'h8001);
        test_ramps(500);
        idle_on = 1'b0;
        set_shape(1'b1, 16'h0000);
        test_ramps(250);
        idle_on = 1'b1;
        set_shape(1'b1, 16'h7FFF);
        test_ramps(250);
        set_shape(1'b1, 16'h0001);
        test_ramps(100);
        set_shape(1'b1, 16'($urandom_range(16'h7FFE, 2)));
        test_ramps(250);
        set_shape(1'b1, 16'h8000);
        test_ramps(200);
        set_shape(1'b1, 16'hFFFF);
        test_ramps(100);
        set_shape(1'b1, 16'($urandom_range(16'hFFFE, 16'h8001)));
        test_ramps(250);
        test_backpressure();

        drain();
        repeat (100) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
